@@ hw/rtl/oss_pkg.sv @@
`timescale 1ns / 1ps
package oss_pkg;
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_COUNT  = 2'd2,
		REQ_KTH    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2,
		ST_BADRANK = 2'd3
	} status_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;      // capture request, reset search bounds
		logic search;    // one binary search step (read issued at mid)
		logic rd_rank;   // issue read at rank-1
		logic shift_up;  // one insert shift step
		logic shift_dn;  // one delete shift step
		logic put_key;   // write key at pos, count++
		logic dec_count; // count--
		logic start_up;  // set shift pointer for insert
		logic start_dn;  // set shift pointer for delete
		logic rd_pos;    // read entry at pos
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic search_done;
		logic found;
		logic full;
		logic rank_ok;
		logic shift_done;
	} stat_t;
endpackage

@@ hw/rtl/oss_datapath.sv @@
`timescale 1ns / 1ps
module oss_datapath import oss_pkg::*; #(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic [1:0]           req_type,
	input  logic signed [31:0]   key,
	input  logic [10:0]          rank,
	output logic signed [31:0]   res_answer,
	input  logic [1:0]           res_status,
	input  logic                 res_load,
	output logic [1:0]           res_status_q
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [KEY_WIDTH-1:0] mem_q [CAPACITY];
	logic [KEY_WIDTH-1:0] rdata_q;
	logic [KEY_WIDTH-1:0] ord_key_q;
	logic [CW-1:0]        count_q, lo_q, hi_q, ptr_q;
	logic [10:0]          rank_q;
	logic [1:0]           req_q;
	logic [KEY_WIDTH-1:0] key_ord;
	logic [CW-1:0]        mid;
	logic [CW-1:0]        rd_addr;
	logic                 rd_en, wr_en;
	logic [CW-1:0]        wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;
	logic                 pend_q;  // search or shift read in flight
	logic [CW-1:0]        pmid_q;
	logic [31:0]          ans_q;

	// sign-extend/truncate to KEY_WIDTH, flip sign bit -> unsigned order
	always_comb begin
		logic [63:0] ext;
		ext = 64'(signed'(key));
		key_ord = ext[KEY_WIDTH-1:0];
		key_ord[KEY_WIDTH-1] = ~key_ord[KEY_WIDTH-1];
	end

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rdata_q;
		if (cmd.search && (lo_q < hi_q) && !pend_q) begin
			rd_en = 1'b1; rd_addr = mid;
		end
		if (cmd.rd_rank) begin
			rd_en = 1'b1; rd_addr = CW'(rank_q - 11'd1);
		end
		if (cmd.rd_pos) begin
			rd_en = 1'b1; rd_addr = lo_q;
		end
		if (cmd.shift_up) begin
			// insert: ptr walks down; read ptr-1 then write ptr
			if (!pend_q) begin
				rd_en = 1'b1; rd_addr = ptr_q - 1'b1;
			end else begin
				wr_en = 1'b1; wr_addr = ptr_q;
			end
		end
		if (cmd.shift_dn) begin
			// delete: ptr walks up; read ptr+1 then write ptr
			if (!pend_q) begin
				rd_en = 1'b1; rd_addr = ptr_q + 1'b1;
			end else begin
				wr_en = 1'b1; wr_addr = ptr_q;
			end
		end
		if (cmd.put_key) begin
			wr_en = 1'b1; wr_addr = lo_q; wr_data = ord_key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem_q[rd_addr[AW-1:0]];
		if (wr_en)
			mem_q[wr_addr[AW-1:0]] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			ptr_q   <= '0;
			pend_q  <= 1'b0;
			pmid_q  <= '0;
			res_status_q <= ST_DONE;
		end else begin
			if (cmd.load) begin
				lo_q   <= '0;
				hi_q   <= count_q;
				pend_q <= 1'b0;
			end
			if (cmd.search) begin
				if (pend_q) begin
					pend_q <= 1'b0;
					if (rdata_q < ord_key_q) lo_q <= pmid_q + 1'b1;
					else                     hi_q <= pmid_q;
				end else if (lo_q < hi_q) begin
					pend_q <= 1'b1;
					pmid_q <= mid;
				end
			end
			if (cmd.start_up) begin
				ptr_q  <= count_q;
				pend_q <= 1'b0;
			end
			if (cmd.start_dn) begin
				ptr_q  <= lo_q;
				pend_q <= 1'b0;
			end
			if (cmd.shift_up) begin
				pend_q <= ~pend_q;
				if (pend_q) ptr_q <= ptr_q - 1'b1;
			end
			if (cmd.shift_dn) begin
				pend_q <= ~pend_q;
				if (pend_q) ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.put_key)   count_q <= count_q + 1'b1;
			if (cmd.dec_count) count_q <= count_q - 1'b1;
			if (res_load)      res_status_q <= res_status;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ord_key_q <= key_ord;
			rank_q    <= rank;
			req_q     <= req_type;
		end
		if (res_load) begin
			if (res_status == ST_DONE && req_t'(req_q) == REQ_COUNT)
				ans_q <= 32'(lo_q);
			else if (res_status == ST_DONE && req_t'(req_q) == REQ_KTH) begin
				logic [KEY_WIDTH-1:0] k;
				k = rdata_q;
				k[KEY_WIDTH-1] = ~k[KEY_WIDTH-1];
				ans_q <= 32'(k);
			end else
				ans_q <= '0;
		end
	end

	assign res_answer = ans_q;

	assign stat.search_done = !pend_q && !(lo_q < hi_q);
	assign stat.found       = (lo_q < count_q) && (rdata_q == ord_key_q);
	assign stat.full        = (count_q >= CW'(CAPACITY));
	assign stat.rank_ok     = (rank_q != 11'd0) && (32'(rank_q) <= 32'(count_q));
	assign stat.shift_done  = cmd.shift_up ? (ptr_q == lo_q)
	                        : (ptr_q + 1'b1 >= count_q);
endmodule

@@ hw/rtl/oss_ctrl.sv @@
`timescale 1ns / 1ps
module oss_ctrl import oss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	output logic       out_valid,
	input  logic       out_ready,
	input  stat_t      stat,
	output cmd_t       cmd,
	output logic [1:0] res_status,
	output logic       res_load
);
	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_RDPOS, S_DECIDE, S_RANK, S_RANKW,
		S_SHUP, S_SHDN, S_PUT, S_OUT
	} state_t;

	state_t state_q;
	req_t   req_q;
	logic   ovalid_q;

	assign in_ready  = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;

	always_comb begin
		cmd = '0;
		res_load = 1'b0;
		res_status = ST_DONE;
		case (state_q)
			S_IDLE:   cmd.load = in_valid && in_ready;
			S_SEARCH: cmd.search = 1'b1;
			S_RDPOS:  cmd.rd_pos = 1'b1;
			S_DECIDE: begin
				case (req_q)
					REQ_INSERT: begin
						if (stat.found)     begin res_load = 1'b1; res_status = ST_IGNORED; end
						else if (stat.full) begin res_load = 1'b1; res_status = ST_FULL; end
						else cmd.start_up = 1'b1;
					end
					REQ_DELETE: begin
						if (!stat.found) begin res_load = 1'b1; res_status = ST_IGNORED; end
						else cmd.start_dn = 1'b1;
					end
					default: res_load = 1'b1;
				endcase
			end
			S_RANK:   cmd.rd_rank = stat.rank_ok;
			S_RANKW: begin
				res_load = 1'b1;
				res_status = stat.rank_ok ? ST_DONE : ST_BADRANK;
			end
			S_SHUP:   cmd.shift_up = 1'b1;
			S_SHDN:   cmd.shift_dn = 1'b1;
			S_PUT: begin
				res_load = 1'b1;
				if (req_q == REQ_INSERT) cmd.put_key = 1'b1;
				else cmd.dec_count = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= REQ_INSERT;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					req_q   <= req_t'(req_type);
					state_q <= (req_t'(req_type) == REQ_KTH) ? S_RANK : S_SEARCH;
				end
				S_SEARCH: if (stat.search_done) state_q <= S_RDPOS;
				S_RDPOS:  state_q <= S_DECIDE;
				S_DECIDE: begin
					if (res_load) state_q <= S_OUT;
					else if (req_q == REQ_INSERT) state_q <= S_SHUP;
					else state_q <= S_SHDN;
				end
				S_RANK:  state_q <= S_RANKW;
				S_RANKW: state_q <= S_OUT;
				// shift loops: test done on read half, write half commits
				S_SHUP: if (stat.shift_done) state_q <= S_PUT;
				S_SHDN: if (stat.shift_done) state_q <= S_PUT;
				S_PUT:  state_q <= S_OUT;
				S_OUT: begin
					ovalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/order_statistic_set_unit.sv @@
`timescale 1ns / 1ps
// channel  direction  handshake             payload
// request  in         in_valid / in_ready   req_type, key, rank
// result   out        out_valid / out_ready answer, status
//
// Insert/delete move entries one at a time, each move a read of the key
// memory followed by a write (read-then-write shift).
// Reset clears the element count and control; the key memory is not cleared.
// One item at a time; the next item waits until the result is taken.
module order_statistic_set_unit import oss_pkg::*; #(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] key,
	input  logic [10:0]        rank,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] answer,
	output logic [1:0]         status
);
	cmd_t       cmd;
	stat_t      stat;
	logic [1:0] res_status;
	logic       res_load;

	oss_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .req_type,
		.out_valid, .out_ready, .stat, .cmd, .res_status, .res_load
	);

	oss_datapath #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .stat, .req_type, .key, .rank,
		.res_answer(answer), .res_status, .res_load, .res_status_q(status)
	);
endmodule
